>>> rtl/cgec_pkg.sv
// package: shared types, constants and microcode table of the edge color core
`default_nettype none

package cgec_pkg;

	// node count is saturated to this value
	localparam logic [4:0] MAX_VERTICES = 5'd16;

	typedef enum logic [1:0] {
		STEP_IDLE  = 2'd0,
		STEP_CHECK = 2'd1,
		STEP_SCAN  = 2'd2,
		STEP_DONE  = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		COND_NEVER = 2'd0,
		COND_START = 2'd1,
		COND_SHORT = 2'd2,
		COND_FOUND = 2'd3
	} cond_t;

	// one control word per step
	typedef struct packed {
		cond_t cond;
		step_t jump;
		step_t next;
		logic  load;
		logic  init;
		logic  scan;
		logic  emit;
		logic  busy;
	} ucode_t;

	// status from the datapath that the jumps test
	typedef struct packed {
		logic start;
		logic short_done;
		logic found;
	} flags_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '{cond: COND_NEVER, jump: STEP_IDLE, next: STEP_IDLE,
			load: 1'b0, init: 1'b0, scan: 1'b0, emit: 1'b0, busy: 1'b0};
		case (step)
			STEP_IDLE: begin
				w.cond = COND_START;
				w.jump = STEP_CHECK;
				w.next = STEP_IDLE;
				w.load = 1'b1;
			end
			STEP_CHECK: begin
				w.cond = COND_SHORT;
				w.jump = STEP_DONE;
				w.next = STEP_SCAN;
				w.init = 1'b1;
				w.busy = 1'b1;
			end
			STEP_SCAN: begin
				w.cond = COND_FOUND;
				w.jump = STEP_DONE;
				w.next = STEP_SCAN;
				w.scan = 1'b1;
				w.busy = 1'b1;
			end
			STEP_DONE: begin
				w.cond = COND_NEVER;
				w.jump = STEP_IDLE;
				w.next = STEP_IDLE;
				w.emit = 1'b1;
				w.busy = 1'b1;
			end
			default: begin
				w.cond = COND_NEVER;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/complete_graph_edge_color_core.sv
// top level: round-robin tournament round lookup for a complete graph
`default_nettype none

// channel   direction  handshake            payload
// cfg       in         cfg_we               cfg_wdata (vertex_count)
// query     in         start & !busy        rank_a, rank_b
// result    out        done (one cycle)     round_color, round_count
//
// an odd count, an equal pair or an out-of-range node goes from the
// check step straight to done; for an even count n the scan step
// of the microcode checks one round per cycle
// busy is high from the cycle after acceptance through the done cycle
// reset puts the sequencer in idle and the node count at 16
// the receiver cannot stall: done is a single-cycle strobe

module complete_graph_edge_color_core
	import cgec_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire  [4:0] cfg_wdata,
	input  wire        start,
	input  wire  [3:0] rank_a,
	input  wire  [3:0] rank_b,
	output logic       busy,
	output logic       done,
	output logic [3:0] round_color,
	output logic [4:0] round_count
);

	// configuration
	logic [4:0] vertex_count_q;

	// operand and scan registers
	logic [3:0] a_q, b_q;
	logic [3:0] c_q;      // current round
	logic [3:0] p_q;      // partner of the fixed node in this round
	logic [3:0] s_q;      // pair sum (mod n-1) of circle pairs in this round
	logic [3:0] tsum_q;   // (a+b) mod (n-1)
	logic [3:0] color_q;
	logic [4:0] count_q;

	ucode_t ctl;
	flags_t flags;

	logic [4:0] n_eff, m5, sum5, odd_mod, even_mod, rounds, s_dn;
	logic [3:0] fixed_node, p_dn;
	logic       trivial, hit, last_round;

	cgec_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	always_comb begin
		// count saturation and round total
		n_eff  = (vertex_count_q > MAX_VERTICES) ? MAX_VERTICES : vertex_count_q;
		m5     = n_eff - 5'd1;
		rounds = (n_eff == 5'd0) ? 5'd0 : (n_eff[0] ? n_eff : m5);

		// pair sum reduced once; operands of a non-trivial query are below the node count
		sum5     = {1'b0, a_q} + {1'b0, b_q};
		odd_mod  = (sum5 >= n_eff) ? sum5 - n_eff : sum5;
		even_mod = (sum5 >= m5) ? sum5 - m5 : sum5;

		trivial = (a_q == b_q) || (n_eff <= 5'd1)
			|| ({1'b0, a_q} >= n_eff) || ({1'b0, b_q} >= n_eff);

		// circle method: slot i holds (i - c) mod (n-1), so the fixed node
		// meets -c and every other pair sums to -2c
		fixed_node = m5[3:0];
		hit = ((a_q == fixed_node) && (b_q == p_q))
			|| ((b_q == fixed_node) && (a_q == p_q))
			|| ((a_q != fixed_node) && (b_q != fixed_node) && (tsum_q == s_q));
		last_round = ({1'b0, c_q} == (m5 - 5'd1));

		p_dn = (p_q == 4'd0) ? fixed_node - 4'd1 : p_q - 4'd1;
		s_dn = (s_q >= 4'd2) ? {1'b0, s_q} - 5'd2 : {1'b0, s_q} + m5 - 5'd2;

		flags.start      = start;
		flags.short_done = trivial || n_eff[0];
		flags.found      = hit || last_round;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= MAX_VERTICES;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// datapath driven by the control word
	always_ff @(posedge clk) begin
		if (ctl.load && start) begin
			a_q <= rank_a;
			b_q <= rank_b;
		end
		if (ctl.init) begin
			color_q <= trivial ? 4'd0 : odd_mod[3:0];
			count_q <= rounds;
			tsum_q  <= even_mod[3:0];
			c_q     <= 4'd0;
			p_q     <= 4'd0;
			s_q     <= 4'd0;
		end
		if (ctl.scan) begin
			if (flags.found) begin
				color_q <= hit ? c_q : 4'd0;
			end else begin
				c_q <= c_q + 4'd1;
				p_q <= p_dn;
				s_q <= s_dn[3:0];
			end
		end
	end

	assign busy        = ctl.busy;
	assign done        = ctl.emit;
	assign round_color = color_q;
	assign round_count = count_q;

	// an accepted transaction keeps the core busy and gives no result next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not start work");

	// a result is followed by an idle core
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("core still busy after result");

	// the reported round lies inside the schedule whenever the schedule is not empty
	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (round_count != 5'd0)) |-> ({1'b0, round_color} < round_count))
		else $error("round out of schedule range");

	// the scan never runs past the last round
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan |-> ({1'b0, c_q} < m5))
		else $error("round counter ran past schedule");

endmodule

`default_nettype wire

>>> rtl/cgec_seq.sv
// microcode sequencer: step counter, control table lookup and conditional jumps
`default_nettype none

module cgec_seq
	import cgec_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	input  flags_t flags,
	output ucode_t ctl
);

	step_t step_q;
	logic  take;

	always_comb begin
		ctl = ucode_rom(step_q);
		case (ctl.cond)
			COND_NEVER: take = 1'b0;
			COND_START: take = flags.start;
			COND_SHORT: take = flags.short_done;
			COND_FOUND: take = flags.found;
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= take ? ctl.jump : ctl.next;
		end
	end

endmodule

`default_nettype wire

>>> test/round_lookup_checker.sv
// checker: predicts the tournament round of each pair query and compares the results
`timescale 1ns / 100ps
`default_nettype none

module round_lookup_checker
	import cgec_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire        [4:0] cfg_wdata,
	input  wire              start,
	input  wire              busy,
	input  wire        [3:0] rank_a,
	input  wire        [3:0] rank_b,
	input  wire              done,
	input  wire        [3:0] round_color,
	input  wire        [4:0] round_count,
	output int unsigned      pending_rounds,
	output int unsigned      error_count
);

	typedef struct packed {
		logic [3:0] color;
		logic [4:0] count;
	} round_info_t;

	round_info_t expected_rounds[$];
	logic [4:0]  node_count;

	function automatic int clamp_nodes(input logic [4:0] raw);
		return (raw > MAX_VERTICES) ? int'(MAX_VERTICES) : int'(raw);
	endfunction

	function automatic logic [4:0] rounds_for(input int n);
		if (n == 0)
			return 5'd0;
		return (n % 2 == 0) ? 5'(n - 1) : 5'(n);
	endfunction

	function automatic bit pair_matches(input int a, input int b, input int x, input int y);
		return (a == x && b == y) || (a == y && b == x);
	endfunction

	// circle method for even counts, closed form for odd counts
	function automatic logic [3:0] meeting_round(input int a, input int b, input int n);
		int circle[16];
		int c;
		int i;
		int anchor;
		int tail;
		if (a == b || n <= 1 || a >= n || b >= n)
			return 4'd0;
		if (n % 2 == 1)
			return 4'((a + b) % n);
		for (i = 0; i + 1 < n; i++)
			circle[i] = i;
		anchor = n - 1;
		for (c = 0; c + 1 < n; c++) begin
			if (pair_matches(a, b, anchor, circle[0]))
				return 4'(c);
			for (i = 1; i < n / 2; i++) begin
				if (pair_matches(a, b, circle[i], circle[n - 1 - i]))
					return 4'(c);
			end
			tail = circle[n - 2];
			for (i = n - 2; i > 0; i--)
				circle[i] = circle[i - 1];
			circle[0] = tail;
		end
		return 4'd0;
	endfunction

	task automatic report_error(input string field, input int got, input int want);
		$display("ERROR %0t: %s is %0d, predicted %0d", $time, field, got, want);
		error_count++;
	endtask

	initial begin
		error_count    = 0;
		pending_rounds = 0;
		node_count     = 5'd16;
	end

	always @(posedge clk or negedge arst_n) begin
		round_info_t want;
		int          n;
		if (!arst_n) begin
			node_count = 5'd16;
			expected_rounds.delete();
		end else begin
			// result transaction: compare with the oldest prediction
			if (done) begin
				if (expected_rounds.size() == 0) begin
					$display("ERROR %0t: result with no query outstanding", $time);
					error_count++;
				end else begin
					want = expected_rounds.pop_front();
					if (round_color !== want.color)
						report_error("round_color", round_color, want.color);
					if (round_count !== want.count)
						report_error("round_count", round_count, want.count);
				end
			end
			// query transaction
			if (start && !busy) begin
				n          = clamp_nodes(node_count);
				want.color = meeting_round(int'(rank_a), int'(rank_b), n);
				want.count = rounds_for(n);
				expected_rounds = {expected_rounds, want};
			end
			if (cfg_we)
				node_count = cfg_wdata;
		end
		pending_rounds = expected_rounds.size();
	end

endmodule

`default_nettype wire

>>> test/tb_complete_graph_edge_color_core.sv
// testbench top: stimulus and verdict for the complete graph edge color core
`timescale 1ns / 100ps
`default_nettype none

module tb_complete_graph_edge_color_core;

	import cgec_pkg::*;

	// cycles without any transaction before the run is declared hung
	localparam int IDLE_LIMIT = 1000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_wdata;
	logic       start;
	logic [3:0] rank_a;
	logic [3:0] rank_b;
	logic       busy;
	logic       done;
	logic [3:0] round_color;
	logic [4:0] round_count;

	int unsigned pending_rounds;
	int unsigned error_count;
	int          idle_cycles;
	int          live_nodes;
	bit          gaps_on;

	complete_graph_edge_color_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.rank_a     (rank_a),
		.rank_b     (rank_b),
		.busy       (busy),
		.done       (done),
		.round_color(round_color),
		.round_count(round_count)
	);

	round_lookup_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.rank_a        (rank_a),
		.rank_b        (rank_b),
		.done          (done),
		.round_color   (round_color),
		.round_count   (round_count),
		.pending_rounds(pending_rounds),
		.error_count   (error_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: any query or result transaction clears the idle count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// random sender gap: mostly none or short, now and then long
	task automatic sender_gap();
		int pick;
		int cycles;
		pick = $urandom_range(0, 99);
		if (!gaps_on || pick < 60)
			cycles = 0;
		else if (pick < 92)
			cycles = $urandom_range(1, 3);
		else
			cycles = $urandom_range(8, 40);
		repeat (cycles) begin
			@(negedge clk);
			start  = 1'b0;
			rank_a = 4'($urandom);
			rank_b = 4'($urandom);
		end
	endtask

	// one query transaction; start stays high if the next one follows at once
	task automatic send_pair(input logic [3:0] a, input logic [3:0] b);
		sender_gap();
		@(negedge clk);
		start  = 1'b1;
		rank_a = a;
		rank_b = b;
		do
			@(posedge clk);
		while (busy);
	endtask

	// hold off until every predicted result has come back and the core is idle
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_rounds != 0 || busy)
			@(negedge clk);
	endtask

	// node count register write, only while idle
	task automatic set_nodes(input logic [4:0] value);
		drain();
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we     = 1'b0;
		live_nodes = (value > MAX_VERTICES) ? int'(MAX_VERTICES) : int'(value);
	endtask

	// random pairs, mostly inside the live node range so the scan runs deep
	task automatic random_pairs(input int count);
		int          pick;
		logic [3:0]  a;
		logic [3:0]  b;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (live_nodes >= 2 && pick < 75) begin
				a = 4'($urandom_range(0, live_nodes - 1));
				b = 4'($urandom_range(0, live_nodes - 1));
			end else if (pick < 85) begin
				a = 4'($urandom);
				b = a;
			end else begin
				a = 4'($urandom);
				b = 4'($urandom);
			end
			send_pair(a, b);
		end
	endtask

	initial begin
		logic [4:0] phase_counts[20];
		int         p;
		phase_counts = '{5'd16, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
			5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd0, 5'd1, 5'd17, 5'd31, 5'd16};

		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 5'd0;
		start      = 1'b0;
		rank_a     = 4'd0;
		rank_b     = 4'd0;
		live_nodes = 16;
		gaps_on    = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset count of 16, field extremes, equal pairs, last node
		send_pair(4'd0, 4'd0);
		send_pair(4'd15, 4'd15);
		send_pair(4'd0, 4'd15);
		send_pair(4'd15, 4'd0);
		send_pair(4'd0, 4'd1);
		send_pair(4'd14, 4'd15);
		send_pair(4'd7, 4'd8);
		send_pair(4'd5, 4'd10);
		send_pair(4'd1, 4'd14);
		send_pair(4'd15, 4'd14);
		// count of zero and one give round 0
		set_nodes(5'd0);
		send_pair(4'd0, 4'd1);
		send_pair(4'd15, 4'd15);
		set_nodes(5'd1);
		send_pair(4'd0, 4'd0);
		send_pair(4'd0, 4'd1);
		// odd count, including a node outside the range
		set_nodes(5'd3);
		send_pair(4'd0, 4'd2);
		send_pair(4'd2, 4'd1);
		send_pair(4'd1, 4'd5);
		// count above the maximum saturates
		set_nodes(5'd31);
		send_pair(4'd15, 4'd0);
		send_pair(4'd3, 4'd9);
		// smallest even count
		set_nodes(5'd2);
		send_pair(4'd0, 4'd1);
		send_pair(4'd1, 4'd0);
		send_pair(4'd0, 4'd3);

		// random phases over all counts, some without sender gaps
		for (p = 0; p < 20; p++) begin
			set_nodes(phase_counts[p]);
			gaps_on = ($urandom_range(0, 3) != 0);
			random_pairs(75);
		end
		repeat (2) begin
			set_nodes(5'($urandom));
			gaps_on = 1'b1;
			random_pairs(50);
		end

		// wait for the last results, then keep watching for stray strobes
		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_rounds == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/cgec_pkg.sv
rtl/cgec_seq.sv
rtl/complete_graph_edge_color_core.sv
test/round_lookup_checker.sv
test/tb_complete_graph_edge_color_core.sv
